// ===== hdl/pcbn_pkg.sv =====
// ----------------------------------------------------------------------------
// pcbn_pkg: shared types and constants for per-class box NMS
// Controller states, command/status structs between controller and datapath,
// register indexes and reset values.
// ----------------------------------------------------------------------------
package pcbn_pkg;

  localparam int MaxBoxesDef = 64;

  localparam logic [15:0] ThrRst  = 16'd29491;
  localparam logic [6:0]  MaxKRst = 7'd64;

  // configuration register indexes
  localparam logic RegThr  = 1'b0;
  localparam logic RegMaxK = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StScanStart,
    StScan,
    StFetch,
    StCand,
    StCheck,
    StKRead,
    StKGeom,
    StCalc1,
    StCalc2,
    StCalc3,
    StCalc4,
    StDecide,
    StKeep,
    StFlush
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;       // store the input box
    logic scan_clr;   // restart the selection scan
    logic scan_step;  // read next score/class entry
    logic fetch;      // take scan winner as candidate
    logic cls_upd;    // open kept list window for candidate class
    logic kinc;       // advance to next kept box
    logic keep;       // candidate survives: record and emit previous
    logic flush;      // emit final result and clear the set
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic found;
    logic k_done;
    logic sup;
    logic quota;
  } sts_t;

endpackage

// ===== hdl/pcbn_ctrl.sv =====
// ----------------------------------------------------------------------------
// pcbn_ctrl: sequencing state machine
// Loads boxes, then repeatedly selects the next box in (class, score, index)
// order, checks it against the kept boxes of its class and emits survivors.
// ----------------------------------------------------------------------------
module pcbn_ctrl
  import pcbn_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic last_box_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy_o
);

  state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (start_i && last_box_i) state_d = StScanStart;
      end
      StScanStart: begin
        if (sts_i.quota) state_d = StFlush;
        else state_d = StScan;
      end
      StScan: begin
        if (sts_i.scan_done) state_d = sts_i.found ? StFetch : StFlush;
      end
      StFetch:  state_d = StCand;
      StCand:   state_d = StCheck;
      StCheck:  state_d = sts_i.k_done ? StKeep : StKRead;
      StKRead:  state_d = StKGeom;
      StKGeom:  state_d = StCalc1;
      StCalc1:  state_d = StCalc2;
      StCalc2:  state_d = StCalc3;
      StCalc3:  state_d = StCalc4;
      StCalc4:  state_d = StDecide;
      StDecide: state_d = sts_i.sup ? StScanStart : StCheck;
      StKeep:   state_d = StScanStart;
      StFlush:  state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o  = '0;
    busy_o = (state_q != StIdle);
    case (state_q)
      StIdle:      cmd_o.load      = start_i;
      StScanStart: cmd_o.scan_clr  = 1'b1;
      StScan:      cmd_o.scan_step = 1'b1;
      StFetch:     cmd_o.fetch     = 1'b1;
      StCand:      cmd_o.cls_upd   = 1'b1;
      StDecide:    cmd_o.kinc      = !sts_i.sup;
      StKeep:      cmd_o.keep      = 1'b1;
      StFlush:     cmd_o.flush     = 1'b1;
      default:     cmd_o           = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/pcbn_dp.sv =====
// ----------------------------------------------------------------------------
// pcbn_dp: box stores, selection scan, overlap arithmetic and result register
// Geometry memory has two read ports (candidate and kept box); the overlap
// test is a four-stage free-running pipeline paced by the controller.
// ----------------------------------------------------------------------------
module pcbn_dp
  import pcbn_pkg::*;
#(
  parameter int MAX_BOXES = MaxBoxesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic        [15:0] cfg_data_i,
  input  logic signed [15:0] box_left_i,
  input  logic signed [15:0] box_top_i,
  input  logic        [15:0] box_width_i,
  input  logic        [15:0] box_height_i,
  input  logic        [15:0] box_score_i,
  input  logic        [7:0]  box_class_i,
  output logic               res_strobe_o,
  output logic signed [15:0] out_left_o,
  output logic signed [15:0] out_top_o,
  output logic        [15:0] out_width_o,
  output logic        [15:0] out_height_o,
  output logic        [15:0] out_score_o,
  output logic        [7:0]  out_class_o,
  output logic               out_valid_o,
  output logic               out_last_o,
  output logic               input_overflow_o
);

  localparam int IdxW = $clog2(MAX_BOXES);
  localparam int CntW = $clog2(MAX_BOXES + 1);
  localparam int CmpW = 8;

  // configuration
  logic [15:0] thr_q;
  logic [6:0]  maxk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= ThrRst;
      maxk_q <= MaxKRst;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegThr) thr_q <= cfg_data_i;
      else maxk_q <= cfg_data_i[6:0];
    end
  end

  // memories
  logic [63:0]     geom_mem [MAX_BOXES];
  logic [23:0]     sc_mem   [MAX_BOXES];
  logic [IdxW-1:0] kept_mem [MAX_BOXES];

  // set control
  logic [CntW-1:0]      loaded_q;
  logic                 ovf_q;
  logic [MAX_BOXES-1:0] visited_q;
  logic [CntW-1:0]      kept_cnt_q;
  logic [CntW-1:0]      kaddr_q;
  logic [CntW-1:0]      cls_base_q;
  logic                 have_cls_q;
  logic [7:0]           cur_cls_q;

  // scan
  logic [CntW-1:0] scan_j_q;
  logic            sc_vld_q;
  logic [IdxW-1:0] sc_idx_q;
  logic [23:0]     sc_q;
  logic            found_q;
  logic [IdxW-1:0] best_idx_q;
  logic [15:0]     best_score_q;
  logic [7:0]      best_cls_q;
  logic            better;

  // candidate and kept box
  logic [IdxW-1:0] cand_idx_q;
  logic [63:0]     ga_q;
  logic [IdxW-1:0] kidx_q;
  logic [63:0]     kg_q;

  // overlap pipeline
  logic [31:0] carea_q, karea_q, inter_q;
  logic [15:0] dx_q, dy_q;
  logic [33:0] uni_q;
  logic [49:0] prod_q;
  logic        uni_nz_q;

  // pending result
  logic        pend_vld_q;
  logic [63:0] pend_geom_q;
  logic [15:0] pend_score_q;
  logic [7:0]  pend_cls_q;

  // load and memory ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (loaded_q < CntW'(MAX_BOXES))) begin
      geom_mem[loaded_q[IdxW-1:0]] <= {box_left_i, box_top_i, box_width_i, box_height_i};
      sc_mem[loaded_q[IdxW-1:0]]   <= {box_score_i, box_class_i};
    end
    if (cmd_i.keep) kept_mem[kept_cnt_q[IdxW-1:0]] <= cand_idx_q;
    ga_q   <= geom_mem[cand_idx_q];
    kidx_q <= kept_mem[kaddr_q[IdxW-1:0]];
    kg_q   <= geom_mem[kidx_q];
    if (cmd_i.scan_step && (scan_j_q < loaded_q)) sc_q <= sc_mem[scan_j_q[IdxW-1:0]];
  end

  // selection: smallest class, then highest score, then lowest index
  always_comb begin
    better = !found_q || (sc_q[7:0] < best_cls_q) ||
             ((sc_q[7:0] == best_cls_q) && (sc_q[23:8] > best_score_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_j_q <= '0;
      sc_vld_q <= 1'b0;
      found_q  <= 1'b0;
    end else if (cmd_i.scan_clr) begin
      scan_j_q <= '0;
      sc_vld_q <= 1'b0;
      found_q  <= 1'b0;
    end else if (cmd_i.scan_step) begin
      sc_vld_q <= (scan_j_q < loaded_q);
      if (scan_j_q < loaded_q) scan_j_q <= scan_j_q + 1'b1;
      if (sc_vld_q && !visited_q[sc_idx_q] && better) found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step) begin
      sc_idx_q <= scan_j_q[IdxW-1:0];
      if (sc_vld_q && !visited_q[sc_idx_q] && better) begin
        best_idx_q   <= sc_idx_q;
        best_score_q <= sc_q[23:8];
        best_cls_q   <= sc_q[7:0];
      end
    end
    if (cmd_i.fetch) cand_idx_q <= best_idx_q;
  end

  // set bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q   <= '0;
      ovf_q      <= 1'b0;
      visited_q  <= '0;
      kept_cnt_q <= '0;
      kaddr_q    <= '0;
      cls_base_q <= '0;
      have_cls_q <= 1'b0;
      cur_cls_q  <= '0;
      pend_vld_q <= 1'b0;
    end else if (cmd_i.flush) begin
      loaded_q   <= '0;
      ovf_q      <= 1'b0;
      visited_q  <= '0;
      kept_cnt_q <= '0;
      kaddr_q    <= '0;
      cls_base_q <= '0;
      have_cls_q <= 1'b0;
      pend_vld_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        if (loaded_q < CntW'(MAX_BOXES)) loaded_q <= loaded_q + 1'b1;
        else ovf_q <= 1'b1;
      end
      if (cmd_i.fetch) visited_q[best_idx_q] <= 1'b1;
      // every candidate walks the kept window of its class from its start, stopping at the first suppressing box
      if (cmd_i.cls_upd) begin
        if (!have_cls_q || (best_cls_q != cur_cls_q)) begin
          have_cls_q <= 1'b1;
          cur_cls_q  <= best_cls_q;
          cls_base_q <= kept_cnt_q;
          kaddr_q    <= kept_cnt_q;
        end else begin
          kaddr_q <= cls_base_q;
        end
      end
      if (cmd_i.kinc) kaddr_q <= kaddr_q + 1'b1;
      if (cmd_i.keep) begin
        kept_cnt_q <= kept_cnt_q + 1'b1;
        pend_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.keep) begin
      pend_geom_q  <= ga_q;
      pend_score_q <= best_score_q;
      pend_cls_q   <= best_cls_q;
    end
  end

  // overlap arithmetic: edges, extents, products, union, threshold product
  logic signed [17:0] al, ar, at, ab, bl, br, bt, bb;
  logic signed [17:0] x1, x2, y1, y2, dxs, dys;

  always_comb begin
    al  = 18'(signed'(ga_q[63:48]));
    at  = 18'(signed'(ga_q[47:32]));
    ar  = al + signed'({2'b00, ga_q[31:16]});
    ab  = at + signed'({2'b00, ga_q[15:0]});
    bl  = 18'(signed'(kg_q[63:48]));
    bt  = 18'(signed'(kg_q[47:32]));
    br  = bl + signed'({2'b00, kg_q[31:16]});
    bb  = bt + signed'({2'b00, kg_q[15:0]});
    x1  = (al > bl) ? al : bl;
    y1  = (at > bt) ? at : bt;
    x2  = (ar < br) ? ar : br;
    y2  = (ab < bb) ? ab : bb;
    dxs = x2 - x1;
    dys = y2 - y1;
  end

  always_ff @(posedge clk_i) begin
    dx_q     <= (dxs > 18'sd0) ? dxs[15:0] : 16'd0;
    dy_q     <= (dys > 18'sd0) ? dys[15:0] : 16'd0;
    carea_q  <= ga_q[31:16] * ga_q[15:0];
    karea_q  <= kg_q[31:16] * kg_q[15:0];
    inter_q  <= dx_q * dy_q;
    uni_q    <= 34'(carea_q) + 34'(karea_q) - 34'(inter_q);
    prod_q   <= 50'(thr_q) * 50'(uni_q);
    uni_nz_q <= (uni_q != '0);
  end

  // status
  always_comb begin
    sts_o.scan_done = (scan_j_q == loaded_q) && !sc_vld_q;
    sts_o.found     = found_q;
    sts_o.k_done    = (kaddr_q == kept_cnt_q);
    sts_o.sup       = uni_nz_q && ({2'b00, inter_q, 16'd0} > prod_q);
    sts_o.quota     = (CmpW'(kept_cnt_q) >= CmpW'(maxk_q));
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_strobe_o <= 1'b0;
    end else begin
      res_strobe_o <= (cmd_i.keep && pend_vld_q) || cmd_i.flush;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((cmd_i.keep && pend_vld_q) || cmd_i.flush) begin
      out_last_o       <= cmd_i.flush;
      input_overflow_o <= ovf_q;
      out_valid_o      <= pend_vld_q;
      if (pend_vld_q) begin
        out_left_o   <= pend_geom_q[63:48];
        out_top_o    <= pend_geom_q[47:32];
        out_width_o  <= pend_geom_q[31:16];
        out_height_o <= pend_geom_q[15:0];
        out_score_o  <= pend_score_q;
        out_class_o  <= pend_cls_q;
      end else begin
        out_left_o   <= '0;
        out_top_o    <= '0;
        out_width_o  <= '0;
        out_height_o <= '0;
        out_score_o  <= '0;
        out_class_o  <= '0;
      end
    end
  end

endmodule

// ===== hdl/per_class_box_nms_top.sv =====
// ----------------------------------------------------------------------------
// per_class_box_nms_top: greedy per-class non-maximum suppression
// Loads one box per cycle while not busy; the last box starts selection and
// suppression. After the last box, each visited box is selected by a scan
// over the n stored boxes plus a fetch, compared through the overlap pipeline
// with each kept box of its class, and recorded when it is kept. The set
// closes with a last scan and a flush.
// Throughput: one set at a time; busy stays high until the set is done.
// Results are one-cycle strobes with no back-pressure; the final result is
// registered from the flush step and comes out as busy falls. Reset is
// asynchronous, active low, and clears the set; the registers return to their reset values.
// ----------------------------------------------------------------------------
module per_class_box_nms_top
  import pcbn_pkg::*;
#(
  parameter int MAX_BOXES = MaxBoxesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic        [15:0] cfg_data_i,
  input  logic signed [15:0] box_left_i,
  input  logic signed [15:0] box_top_i,
  input  logic        [15:0] box_width_i,
  input  logic        [15:0] box_height_i,
  input  logic        [15:0] box_score_i,
  input  logic        [7:0]  box_class_i,
  input  logic               last_box_i,
  output logic               res_strobe_o,
  output logic signed [15:0] out_left_o,
  output logic signed [15:0] out_top_o,
  output logic        [15:0] out_width_o,
  output logic        [15:0] out_height_o,
  output logic        [15:0] out_score_o,
  output logic        [7:0]  out_class_o,
  output logic               out_valid_o,
  output logic               out_last_o,
  output logic               input_overflow_o
);

  cmd_t cmd;
  sts_t sts;

  pcbn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .last_box_i (last_box_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy_o     (busy_o)
  );

  pcbn_dp #(
    .MAX_BOXES (MAX_BOXES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .box_left_i       (box_left_i),
    .box_top_i        (box_top_i),
    .box_width_i      (box_width_i),
    .box_height_i     (box_height_i),
    .box_score_i      (box_score_i),
    .box_class_i      (box_class_i),
    .res_strobe_o     (res_strobe_o),
    .out_left_o       (out_left_o),
    .out_top_o        (out_top_o),
    .out_width_o      (out_width_o),
    .out_height_o     (out_height_o),
    .out_score_o      (out_score_o),
    .out_class_o      (out_class_o),
    .out_valid_o      (out_valid_o),
    .out_last_o       (out_last_o),
    .input_overflow_o (input_overflow_o)
  );

  // a result only comes out of a running set
  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> $past(busy_o))
    else $error("result strobe without a running set");

  // an empty-set marker is always the final result
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && !out_valid_o) |-> out_last_o)
    else $error("empty marker not flagged last");

  // the final result ends the set
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && out_last_o) |-> !busy_o)
    else $error("block still busy after final result");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression bench for per_class_box_nms_top
// Drives box sets through the box input port, predicts the kept boxes with a
// per-class greedy overlap filter of its own and checks every result strobe.
// Sender gaps vary by phase; registers change between drained phases.
// ----------------------------------------------------------------------------
module tb
  import pcbn_pkg::*;
();

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic        [15:0] width;
    logic        [15:0] height;
    logic        [15:0] score;
    logic        [7:0]  cls;
    logic               last;
  } box_t;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic        [15:0] width;
    logic        [15:0] height;
    logic        [15:0] score;
    logic        [7:0]  cls;
    logic               valid;
    logic               last;
    logic               ovf;
  } det_t;

  // Scoreboard: holds the open set, predicts the kept boxes on its last box
  class nms_scoreboard;
    box_t        held[64];
    int          held_n;
    bit          ovf_seen;
    logic [15:0] iou_thr;
    logic [6:0]  kept_limit;
    det_t        kept_q[$];
    int          mismatches;

    function new();
      iou_thr    = ThrRst;
      kept_limit = MaxKRst;
    endfunction

    function void set_reg(logic idx, logic [15:0] v);
      if (idx == RegThr) iou_thr = v;
      else kept_limit = v[6:0];
    endfunction

    // true when box a is dropped because of kept box b
    function bit too_close(box_t a, box_t b);
      longint al, at, ar, ab, bl, bt, br, bb, x1, y1, x2, y2, inter, uni;
      al = $signed(a.left);  at = $signed(a.top);
      bl = $signed(b.left);  bt = $signed(b.top);
      ar = al + longint'(a.width);  ab = at + longint'(a.height);
      br = bl + longint'(b.width);  bb = bt + longint'(b.height);
      x1 = (al > bl) ? al : bl;
      y1 = (at > bt) ? at : bt;
      x2 = (ar < br) ? ar : br;
      y2 = (ab < bb) ? ab : bb;
      inter = (x2 <= x1 || y2 <= y1) ? 0 : (x2 - x1) * (y2 - y1);
      uni = longint'(a.width) * longint'(a.height)
          + longint'(b.width) * longint'(b.height) - inter;
      return uni > 0 && inter * 65536 > longint'(iou_thr) * uni;
    endfunction

    // stable descending sort, then greedy filter class by class
    function void close_set();
      int   order[64];
      bit   picked[64];
      det_t outs[$];
      det_t d;
      int   q, cur, i;
      bit   keep;
      for (int p = 0; p < held_n; p++) begin
        q = p;
        cur = p;
        while (q > 0 && held[order[q-1]].score < held[cur].score) begin
          order[q] = order[q-1];
          q--;
        end
        order[q] = cur;
      end
      for (int p = 0; p < 64; p++) picked[p] = 0;
      for (int c = 0; c < 256 && outs.size() < kept_limit; c++) begin
        for (int p = 0; p < held_n && outs.size() < kept_limit; p++) begin
          i = order[p];
          if (held[i].cls != c) continue;
          keep = 1;
          for (int k = 0; k < held_n; k++)
            if (picked[k] && held[k].cls == c && too_close(held[i], held[k])) keep = 0;
          if (keep) begin
            picked[i] = 1;
            d = '{held[i].left, held[i].top, held[i].width, held[i].height,
                  held[i].score, held[i].cls, 1'b1, 1'b0, ovf_seen};
            outs.insert(outs.size(), d);
          end
        end
      end
      if (outs.size() == 0) begin
        d = '0;
        d.ovf = ovf_seen;
        outs.insert(0, d);
      end
      outs[outs.size()-1].last = 1'b1;
      foreach (outs[j]) kept_q.insert(kept_q.size(), outs[j]);
      held_n = 0;
      ovf_seen = 0;
    endfunction

    // accepted input transaction
    function void note_box(box_t b);
      if (held_n < 64) begin
        held[held_n] = b;
        held_n++;
      end else begin
        ovf_seen = 1;
      end
      if (b.last) close_set();
    endfunction

    // accepted result transaction
    function void check_det(det_t got);
      det_t want;
      if (kept_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = kept_q.pop_front();
      if (got.left !== want.left || got.top !== want.top || got.width !== want.width ||
          got.height !== want.height || got.score !== want.score ||
          got.cls !== want.cls || got.valid !== want.valid ||
          got.last !== want.last || got.ovf !== want.ovf) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: exp %p got %p", want, got);
      end
    endfunction
  endclass

  logic               clk_i, rst_ni, start_i, busy_o;
  logic               cfg_we_i, cfg_idx_i;
  logic        [15:0] cfg_data_i;
  logic signed [15:0] box_left_i, box_top_i;
  logic        [15:0] box_width_i, box_height_i, box_score_i;
  logic        [7:0]  box_class_i;
  logic               last_box_i;
  logic               res_strobe_o;
  logic signed [15:0] out_left_o, out_top_o;
  logic        [15:0] out_width_o, out_height_o, out_score_o;
  logic        [7:0]  out_class_o;
  logic               out_valid_o, out_last_o, input_overflow_o;

  nms_scoreboard sb = new();
  int idle_pct;
  int quiet_cycles;
  int boxes_sent;
  logic signed [15:0] anc_l, anc_t;
  logic        [15:0] anc_w, anc_h;

  per_class_box_nms_top u_top (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_strobe_o)
        sb.check_det('{out_left_o, out_top_o, out_width_o, out_height_o, out_score_o,
                       out_class_o, out_valid_o, out_last_o, input_overflow_o});
      if (res_strobe_o || (start_i && !busy_o)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles > 400000) begin
        $display("per_class_box_nms_top regression: fail");
        $finish;
      end
    end
  end

  task automatic write_regs(logic [15:0] thr, logic [6:0] kmax);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= RegThr;
    cfg_data_i <= thr;
    @(negedge clk_i);
    cfg_idx_i  <= RegMaxK;
    cfg_data_i <= {9'd0, kmax};
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(RegThr, thr);
    sb.set_reg(RegMaxK, {9'd0, kmax});
  endtask

  task automatic send_box(box_t b);
    @(negedge clk_i);
    start_i      <= 1'b1;
    box_left_i   <= b.left;
    box_top_i    <= b.top;
    box_width_i  <= b.width;
    box_height_i <= b.height;
    box_score_i  <= b.score;
    box_class_i  <= b.cls;
    last_box_i   <= b.last;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note_box(b);
    boxes_sent++;
    if ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk_i);
    end
  endtask

  // hold the sender until every expected result is in and the block is idle
  task automatic drain();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (sb.kept_q.size() != 0) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // mostly boxes clustered around the set anchor, some fully random
  function automatic box_t rand_box(bit last);
    box_t b;
    b = box_t'({$urandom, $urandom, $urandom});
    if ($urandom_range(0, 99) < 80) begin
      b.left   = anc_l + 16'($urandom_range(0, 96)) - 16'sd48;
      b.top    = anc_t + 16'($urandom_range(0, 96)) - 16'sd48;
      b.width  = anc_w + 16'($urandom_range(0, 64));
      b.height = anc_h + 16'($urandom_range(0, 64));
      b.cls    = 8'($urandom_range(0, 3));
    end
    if ($urandom_range(0, 9) == 0) b.score = 16'($urandom_range(0, 3)) << 14;
    if ($urandom_range(0, 19) == 0) b.width = 16'd0;
    if ($urandom_range(0, 19) == 0) b.height = 16'd0;
    b.last = last;
    return b;
  endfunction

  task automatic rand_set(int n);
    anc_l = 16'($urandom);
    anc_t = 16'($urandom);
    anc_w = 16'($urandom_range(16, 400));
    anc_h = 16'($urandom_range(16, 400));
    for (int k = 0; k < n; k++) send_box(rand_box(k == n - 1));
  endtask

  task automatic run_phase(int pct, int items, bit big, bit mid_drain);
    int start_cnt;
    idle_pct = pct;
    start_cnt = boxes_sent;
    if (big) rand_set(66);
    while (boxes_sent - start_cnt < items) begin
      rand_set($urandom_range(1, 8));
      if (mid_drain && boxes_sent - start_cnt > items / 2) begin
        drain();
        mid_drain = 0;
      end
    end
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = RegThr;
    cfg_data_i = '0;
    box_left_i = '0;
    box_top_i = '0;
    box_width_i = '0;
    box_height_i = '0;
    box_score_i = '0;
    box_class_i = '0;
    last_box_i = 1'b0;
    quiet_cycles = 0;
    boxes_sent = 0;
    idle_pct = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed sets
    write_regs(ThrRst, MaxKRst);
    // field extremes; identical copy is suppressed; zero-area last box
    send_box('{-16'sd32768, -16'sd32768, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255, 1'b0});
    send_box('{-16'sd32768, -16'sd32768, 16'hFFFF, 16'hFFFF, 16'h0000, 8'd255, 1'b0});
    send_box('{16'sd32767, 16'sd32767, 16'h0000, 16'h0000, 16'h0000, 8'd0, 1'b1});
    // identical zero-area boxes: empty union never suppresses
    send_box('{16'sd100, 16'sd100, 16'd0, 16'd50, 16'd900, 8'd7, 1'b0});
    send_box('{16'sd100, 16'sd100, 16'd0, 16'd50, 16'd900, 8'd7, 1'b1});
    // score ties within a class keep arrival order; the smaller class comes first
    send_box('{16'sd0, 16'sd0, 16'd10, 16'd10, 16'd500, 8'd5, 1'b0});
    send_box('{16'sd100, 16'sd0, 16'd10, 16'd10, 16'd500, 8'd5, 1'b0});
    send_box('{16'sd200, 16'sd0, 16'd10, 16'd10, 16'd500, 8'd1, 1'b0});
    send_box('{16'sd0, 16'sd0, 16'd10, 16'd10, 16'd500, 8'd5, 1'b1});
    // partial overlap below the threshold
    send_box('{16'sd0, 16'sd0, 16'd160, 16'd160, 16'd3000, 8'd2, 1'b0});
    send_box('{16'sd80, 16'sd0, 16'd160, 16'd160, 16'd4000, 8'd2, 1'b1});
    drain();

    run_phase(0, 90, 1'b1, 1'b0);
    write_regs(16'd0, 7'd64);
    run_phase(69, 80, 1'b0, 1'b1);
    write_regs(16'hFFFF, 7'd1);
    run_phase(7, 70, 1'b0, 1'b0);
    write_regs(16'd29491, 7'd0);
    run_phase(0, 25, 1'b0, 1'b0);
    write_regs(16'd16384, 7'd64);
    run_phase(0, 90, 1'b1, 1'b0);
    write_regs(16'd40000, 7'd5);
    run_phase(69, 50, 1'b0, 1'b0);

    repeat (50) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.kept_q.size() == 0) begin
      $display("per_class_box_nms_top regression: pass");
    end else begin
      $display("per_class_box_nms_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/pcbn_pkg.sv
hdl/pcbn_ctrl.sv
hdl/pcbn_dp.sv
hdl/per_class_box_nms_top.sv
tb/tb.sv
